// ===== hdl/assert_macros.svh =====
// assertion macros used by the sketch core rtl file
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/hll_pkg.sv =====
// shared types and constants of the hyperloglog sketch core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hll_pkg;
   localparam int unsigned DEF_INDEX_BITS = 4;
   localparam int unsigned RANK_W = 6;
   localparam int unsigned ALPHA_NUM = 7213;
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_ESTIMATE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_INS, ST_SUM, ST_SUM_END, ST_KLOAD, ST_KMUL,
      ST_DIV, ST_EVAL, ST_LC_INIT, ST_SQ, ST_SQ_POST, ST_LN, ST_LN_POST, ST_OUT
   } hll_state_type;
endpackage
`default_nettype wire

// ===== hdl/hyperloglog_cardinality_sketch_core.sv =====
// hyperloglog sketch core: rank register memory, estimate sequencer, divider, log unit
// depends on hll_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
// An insert (tuser 0) takes a 64-bit hash: the top INDEX_BITS bits pick one of
// 2^INDEX_BITS six-bit rank registers held in a synchronous memory with one read
// and one write port; the register is read, compared with the rank of the
// remaining bits and written back if that rank is larger. An insert reads, then
// writes, and gives no result. An estimate (tuser 1) sweeps the memory, forms
// k*S by shift-add, runs a one-bit-per-cycle restoring divide to a
// (77 + 3*INDEX_BITS)-bit quotient and, when linear counting applies, 32
// squarings and one ln2 scaling on a 32x32 multiplier; the divider and, under
// linear counting, the squarings set the bulk of the latency. After reset a
// clearing pass writes zero to every register, during which no item is accepted.
// The result register lets inserts proceed while an estimate waits to be taken.
module hyperloglog_cardinality_sketch_core
   import hll_pkg::*;
#(
   parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // [63:0] hash_value
   input  wire logic [0:0]  req_tuser,  // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // [63:0] estimate
   output logic [0:0]       rsp_tuser   // [0] used_linear_counting
);
   localparam int unsigned M = 1 << INDEX_BITS;
   localparam int unsigned CW = INDEX_BITS + 1;          // counts 0..M
   localparam int unsigned SW = 65 + INDEX_BITS;         // sum of 2^(64-reg)
   localparam logic [63:0] KVAL = 64'd10 * (64'd1000 * 64'(M) + 64'd1079);
   localparam int unsigned KW = $clog2(KVAL + 64'd1);
   localparam int unsigned KIW = $clog2(KW);
   localparam int unsigned DW = SW + KW;                 // divisor width
   localparam int unsigned NW = 77 + 3 * INDEX_BITS;     // numerator / quotient
   localparam int unsigned DCW = $clog2(NW);
   localparam int unsigned RW = 64 - INDEX_BITS;         // remainder bits of hash
   localparam int unsigned KPW = $clog2(CW);
   localparam logic [NW-1:0] NUM = NW'(ALPHA_NUM) << (3 * INDEX_BITS + 64);
   localparam logic [NW-1:0] THR = NW'((5 * M) / 2);

   // rank register memory
   logic [RANK_W-1:0] mem [M];
   logic              mem_we;
   logic [INDEX_BITS-1:0] mem_waddr, mem_raddr;
   logic [RANK_W-1:0] mem_wdata;
   logic [RANK_W-1:0] rd_ff;

   hll_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           acc_en_ff, acc_en_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [CW-1:0]  zeros_ff, zeros_in;
   logic [DW-1:0]  sh_ff, sh_in, den_ff, den_in, rr_ff, rr_in;
   logic [KIW-1:0] kidx_ff, kidx_in;
   logic [NW-1:0]  nq_ff, nq_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [KPW-1:0] k_ff, k_in;
   logic [63:0]    y_ff, y_in;
   logic [31:0]    frac_ff, frac_in;
   logic [4:0]     it_ff, it_in;
   logic [2:0]     mstep_ff, mstep_in;
   logic [63:0]    pp_ff, pp_in;
   logic [1:0]     psh_ff, psh_in;
   logic [127:0]   acc_ff, acc_in;
   logic [63:0]    est_ff, est_in;
   logic           lc_ff, lc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_est_ff, rsp_est_in;
   logic           rsp_lc_ff, rsp_lc_in;

   // combinational helpers
   logic [RANK_W-1:0] new_rank;
   logic [KPW-1:0]    kpos;
   logic [DW:0]       div_t;
   logic              div_ge;
   logic [63:0]       mul_a, mul_b, l2;
   logic [SW-1:0]     term;
   logic [63:0]       y2;

   // rank of the hash bits below the index: leading zeros plus one
   always_comb begin
      new_rank = RANK_W'(65 - INDEX_BITS);
      for (int i = 0; i < RW; i++) begin
         if (req_tdata[i]) new_rank = RANK_W'(RW - i);
      end
   end

   // position of the top set bit of the zero count
   always_comb begin
      kpos = '0;
      for (int i = 0; i < CW; i++) begin
         if (zeros_ff[i]) kpos = KPW'(i);
      end
   end

   assign term   = SW'(1) << (7'd64 - 7'(rd_ff));
   assign div_t  = {rr_ff, nq_ff[NW-1]};
   assign div_ge = div_t >= {1'b0, den_ff};
   assign l2     = (64'(INDEX_BITS) << 32) - ((64'(k_ff) << 32) | 64'(frac_ff));
   assign mul_a  = (state_ff == ST_LN) ? l2 : y_ff;
   assign mul_b  = (state_ff == ST_LN) ? LN2_Q64 : y_ff;
   assign y2     = acc_ff[125:62];

   assign req_tready = (state_ff == ST_IDLE);
   assign mem_raddr  = (state_ff == ST_IDLE) ? req_tdata[63 -: INDEX_BITS]
                                             : cnt_ff[INDEX_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      acc_en_in = 1'b0;
      idx_in = idx_ff;
      rank_in = rank_ff;
      s_in = s_ff;
      zeros_in = zeros_ff;
      sh_in = sh_ff;
      den_in = den_ff;
      rr_in = rr_ff;
      kidx_in = kidx_ff;
      nq_in = nq_ff;
      dcnt_in = dcnt_ff;
      k_in = k_ff;
      y_in = y_ff;
      frac_in = frac_ff;
      it_in = it_ff;
      mstep_in = '0;
      pp_in = pp_ff;
      psh_in = psh_ff;
      acc_in = '0;
      est_in = est_ff;
      lc_in = lc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_est_in = rsp_est_ff;
      rsp_lc_in = rsp_lc_ff;
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = rank_ff;

      // accumulate the sweep in the cycle after each read
      if (acc_en_ff) begin
         s_in = s_ff + term;
         if (rd_ff == '0) zeros_in = zeros_ff + CW'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = cnt_ff[INDEX_BITS-1:0];
            mem_wdata = '0;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(M - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == OP_INSERT) begin
                  idx_in = req_tdata[63 -: INDEX_BITS];
                  rank_in = new_rank;
                  state_in = ST_INS;
               end else begin
                  cnt_in = '0;
                  s_in = '0;
                  zeros_in = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_INS: begin
            mem_we = rank_ff > rd_ff;
            state_in = ST_IDLE;
         end
         ST_SUM: begin
            acc_en_in = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(M - 1)) state_in = ST_SUM_END;
         end
         ST_SUM_END: state_in = ST_KLOAD;
         ST_KLOAD: begin
            sh_in = DW'(s_ff);
            den_in = '0;
            kidx_in = '0;
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            if (KVAL[kidx_ff]) den_in = den_ff + sh_ff;
            sh_in = sh_ff << 1;
            kidx_in = kidx_ff + KIW'(1);
            if (kidx_ff == KIW'(KW - 1)) begin
               rr_in = '0;
               nq_in = NUM;
               dcnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rr_in = div_ge ? DW'(div_t - {1'b0, den_ff}) : DW'(div_t);
            nq_in = {nq_ff[NW-2:0], div_ge};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(NW - 1)) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (((nq_ff < THR) || ((nq_ff == THR) && (rr_ff == '0))) &&
                (zeros_ff != '0)) begin
               state_in = ST_LC_INIT;
            end else begin
               est_in = (|nq_ff[NW-1:64]) ? '1 : nq_ff[63:0];
               lc_in = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_LC_INIT: begin
            k_in = kpos;
            y_in = 64'(zeros_ff) << (7'd62 - 7'(kpos));
            frac_in = '0;
            it_in = '0;
            state_in = ST_SQ;
         end
         ST_SQ, ST_LN: begin
            // four 32x32 partial products, each accumulated in the cycle after it is formed
            mstep_in = mstep_ff + 3'd1;
            acc_in = acc_ff;
            if (mstep_ff != 3'd4) begin
               pp_in = 64'(mstep_ff[1] ? mul_a[63:32] : mul_a[31:0]) *
                       64'(mstep_ff[0] ? mul_b[63:32] : mul_b[31:0]);
               psh_in = 2'(mstep_ff[1]) + 2'(mstep_ff[0]);
            end
            if (mstep_ff != 3'd0) acc_in = acc_ff + (128'(pp_ff) << {psh_ff, 5'b0});
            if (mstep_ff == 3'd4) state_in = (state_ff == ST_SQ) ? ST_SQ_POST : ST_LN_POST;
         end
         ST_SQ_POST: begin
            if (y2[63]) begin
               y_in = y2 >> 1;
               frac_in = {frac_ff[30:0], 1'b1};
            end else begin
               y_in = y2;
               frac_in = {frac_ff[30:0], 1'b0};
            end
            it_in = it_ff + 5'd1;
            state_in = (it_ff == 5'd31) ? ST_LN : ST_SQ;
         end
         ST_LN_POST: begin
            est_in = (acc_ff[127:64] << INDEX_BITS) >> 32;
            lc_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_est_in = est_ff;
               rsp_lc_in = lc_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         acc_en_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         acc_en_ff <= acc_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rank_ff <= rank_in;
      s_ff <= s_in;
      zeros_ff <= zeros_in;
      sh_ff <= sh_in;
      den_ff <= den_in;
      rr_ff <= rr_in;
      kidx_ff <= kidx_in;
      nq_ff <= nq_in;
      dcnt_ff <= dcnt_in;
      k_ff <= k_in;
      y_ff <= y_in;
      frac_ff <= frac_in;
      it_ff <= it_in;
      mstep_ff <= mstep_in;
      pp_ff <= pp_in;
      psh_ff <= psh_in;
      acc_ff <= acc_in;
      est_ff <= est_in;
      lc_ff <= lc_in;
      rsp_est_ff <= rsp_est_in;
      rsp_lc_ff <= rsp_lc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_est_ff;
   assign rsp_tuser  = rsp_lc_ff;

`include "assert_macros.svh"
   `ASSERT_IMPLY(a_we_state, clock, reset, mem_we, (state_ff == ST_CLEAR) || (state_ff == ST_INS))
   `ASSERT_IMPLY(a_ins_grows, clock, reset, mem_we && (state_ff == ST_INS), rank_ff > rd_ff)
   `ASSERT_IMPLY(a_div_nonzero, clock, reset, state_ff == ST_DIV, den_ff != '0)
   `ASSERT_NEXT(a_rsp_from_out, clock, reset, !rsp_valid_ff && (state_ff != ST_OUT), !rsp_valid_ff)
endmodule
`default_nettype wire

// ===== tb/tb_hyperloglog_cardinality_sketch_core.sv =====
// self-checking testbench of the hyperloglog sketch core: directed table, random hash stream
// depends on hll_pkg and hyperloglog_cardinality_sketch_core
`timescale 1ns / 1ps
`default_nettype none
module tb_hyperloglog_cardinality_sketch_core
   import hll_pkg::*;
();

   localparam int unsigned IDX_W = DEF_INDEX_BITS;
   localparam int unsigned NREG = 1 << IDX_W;
   localparam int RANDOM_ITEMS = 1220;
   localparam int IDLE_LIMIT = 20000;   // cycles without any transfer
   localparam int DRAIN_CYCLES = 600;   // wait at the end before the final verdict

   typedef struct packed {
      logic [63:0] estimate;
      logic        used_lc;
   } sketch_result_type;

   typedef struct {
      logic        op;
      logic [63:0] hash;
      bit          known;      // expected value typed in the row
      logic [63:0] estimate;
      logic        used_lc;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [63:0] hash_value
   logic [0:0]  req_tuser;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] estimate
   logic [0:0]  rsp_tuser;   // [0] used_linear_counting

   hyperloglog_cardinality_sketch_core #(.INDEX_BITS(IDX_W)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // our own copy of the rank registers and the estimates still owed
   logic [RANK_W-1:0] rank_mirror [NREG];
   sketch_result_type pending_estimates [$];
   stim_row_type      directed_rows [$];
   stim_row_type      typed_expect [$];   // typed values for table estimates, in order
   int                error_count;
   int                results_seen;
   int                idle_cycles;
   bit                no_idle_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rank of the hash bits below the index: leading zeros plus one
   function automatic int unsigned hash_rank(logic [63:0] hash);
      logic [63:0] rest;
      int unsigned r;
      rest = hash << IDX_W;
      if (rest == 64'd0) begin
         return 64 - IDX_W + 1;
      end
      r = 1;
      while (!rest[63]) begin
         rest = rest << 1;
         r++;
      end
      return r;
   endfunction

   // log-domain linear counting: NREG * ln(NREG / zeros), q.32 internally
   function automatic logic [63:0] linear_count_value(int unsigned zeros);
      int unsigned k;
      logic [63:0]  y, frac, l2, lnq;
      logic [127:0] sq, prod;
      k = 0;
      while (k < 63 && (zeros >> (k + 1)) != 0) k++;
      y = 64'(zeros) << (62 - k);
      frac = 64'd0;
      for (int i = 0; i < 32; i++) begin
         sq = 128'(y) * 128'(y);
         y = sq[125:62];
         frac = frac << 1;
         if (y[63]) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      l2 = (64'(IDX_W) << 32) - ((64'(k) << 32) | frac);
      prod = 128'(l2) * 128'(LN2_Q64);
      lnq = prod[127:64];
      prod = 128'(NREG) * 128'(lnq);
      return prod[95:32];
   endfunction

   // harmonic-mean estimate with small-range correction
   function automatic sketch_result_type estimate_cardinality();
      sketch_result_type res;
      logic [127:0] sum, num, den, quo, rem;
      logic [127:0] kmul, thr;
      int unsigned zeros;
      sum = '0;
      zeros = 0;
      for (int i = 0; i < NREG; i++) begin
         if (rank_mirror[i] == 0) zeros++;
         sum = sum + (128'd1 << (64 - rank_mirror[i]));
      end
      num = (128'(ALPHA_NUM) * NREG * NREG * NREG) << 64;
      kmul = 128'd10 * (128'd1000 * NREG + 128'd1079);
      den = kmul * sum;
      quo = num / den;
      rem = num % den;
      thr = (128'd5 * NREG) / 2;
      if ((quo < thr || (quo == thr && rem == 0)) && zeros != 0) begin
         res.estimate = linear_count_value(zeros);
         res.used_lc = 1'b1;
      end else begin
         res.estimate = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
         res.used_lc = 1'b0;
      end
      return res;
   endfunction

   // predict on every accepted request transfer
   always @(posedge clock) begin
      int unsigned r, idx;
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser[0] == OP_INSERT) begin
            idx = req_tdata[63 -: IDX_W];
            r = hash_rank(req_tdata);
            if (r > rank_mirror[idx]) rank_mirror[idx] <= RANK_W'(r);
         end else begin
            pending_estimates.push_back(estimate_cardinality());
         end
      end
   end

   // compare every accepted result transfer with the oldest prediction
   always @(posedge clock) begin
      sketch_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (pending_estimates.size() == 0) begin
            $error("unexpected result: estimate %0d used_lc %0d", rsp_tdata, rsp_tuser[0]);
            error_count++;
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_tdata !== want.estimate) begin
               $error("estimate: expected %0d, got %0d", want.estimate, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== want.used_lc) begin
               $error("used_linear_counting: expected %0d, got %0d",
                      want.used_lc, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // typed table values are checked on top of the predictor
   always @(posedge clock) begin
      stim_row_type row;
      if (!reset && rsp_tvalid && rsp_tready && typed_expect.size() != 0) begin
         row = typed_expect.pop_front();
         if (row.known && rsp_tdata !== row.estimate) begin
            $error("table estimate: expected %0d, got %0d", row.estimate, rsp_tdata);
            error_count++;
         end
         if (row.known && rsp_tuser[0] !== row.used_lc) begin
            $error("table used_linear_counting: expected %0d, got %0d",
                   row.used_lc, rsp_tuser[0]);
            error_count++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_length();
      if (no_idle_phase) return 0;
      if ($urandom_range(15) == 0) return $urandom_range(40, 8);
      return ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
   endfunction

   // result side: random stalls plus one long hold-off after 30 results
   initial begin
      bit held;
      int unsigned n;
      held = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_seen >= 30) begin
            held = 1;
            rsp_tready <= 1'b0;
            for (int c = 0; c < 400; c++) @(posedge clock);
         end
         n = gap_length();
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // one request transfer; valid stays high when the next one follows back to back
   task automatic send_item(logic op, logic [63:0] hash);
      int unsigned n;
      n = gap_length();
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= hash;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_estimates.size() != 0);
   endtask

   function automatic void add_row(logic op, logic [63:0] hash, bit known,
                                   logic [63:0] est, logic lc);
      stim_row_type row;
      row = '{op, hash, known, est, lc};
      directed_rows.push_back(row);
   endfunction

   task automatic run_rows(int first, int last);
      for (int i = first; i <= last; i++) begin
         if (directed_rows[i].op == OP_ESTIMATE) typed_expect.push_back(directed_rows[i]);
         send_item(directed_rows[i].op, directed_rows[i].hash);
      end
   endtask

   // random hash, often with a random number of extra leading zeros below the index
   function automatic logic [63:0] random_hash();
      logic [63:0] h;
      int unsigned shift;
      h = {$urandom, $urandom};
      if ($urandom_range(1) == 0) begin
         shift = $urandom_range(64 - IDX_W);
         h = {h[63 -: IDX_W], (h[63-IDX_W:0] >> shift)};
      end
      return h;
   endfunction

   initial begin
      int split;
      logic op;
      error_count = 0;
      results_seen = 0;
      no_idle_phase = 0;
      for (int i = 0; i < NREG; i++) rank_mirror[i] = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;

      // empty sketch gives zero by linear counting
      add_row(OP_ESTIMATE, 64'h0, 1, 64'd0, 1'b1);
      add_row(OP_INSERT, 64'h0000_0000_0000_0000, 0, 0, 0);   // all-zero remainder
      add_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
      add_row(OP_INSERT, 64'h0000_0000_0000_0001, 0, 0, 0);   // smaller rank, kept
      add_row(OP_INSERT, 64'h0800_0000_0000_0000, 0, 0, 0);
      add_row(OP_INSERT, 64'h1400_0000_0000_0000, 0, 0, 0);
      add_row(OP_INSERT, 64'h2000_0000_0000_0001, 0, 0, 0);
      add_row(OP_ESTIMATE, 64'hA5A5_5A5A_0F0F_F0F0, 0, 0, 0);
      add_row(OP_INSERT, 64'hF000_0000_0000_0000, 0, 0, 0);
      add_row(OP_ESTIMATE, 64'h0, 0, 0, 0);
      split = directed_rows.size();
      // every register at its top rank: the raw estimate saturates
      for (int i = 0; i < NREG; i++) add_row(OP_INSERT, {4'(i), 60'h0}, 0, 0, 0);
      add_row(OP_ESTIMATE, 64'h0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_rows(0, split - 1);
      wait_for_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) no_idle_phase = ($urandom_range(3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_for_results();
         op = ($urandom_range(7) == 0) ? OP_ESTIMATE : OP_INSERT;
         send_item(op, random_hash());
      end
      wait_for_results();

      no_idle_phase = 0;
      run_rows(split, directed_rows.size() - 1);
      wait_for_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_estimates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/hll_pkg.sv
hdl/hyperloglog_cardinality_sketch_core.sv
tb/tb_hyperloglog_cardinality_sketch_core.sv
